// ----- sv/pbal_pkg.sv -----
// shared constants and the arctangent table for the pixel box block
// no dependencies; imported by every module of the block
package pbal_pkg;

	// default parameter values
	localparam int COORD_BITS_DEF   = 12;
	localparam int CORDIC_STEPS_DEF = 16;

	// fixed-point formats
	localparam int FRAC_BITS  = 16;
	localparam int ATAN_BITS  = 22;
	localparam int ATAN_COUNT = 24;
	localparam int ANGLE_BITS = 26;
	localparam int GAIN_BITS  = 24;
	localparam int LEN_SHIFT  = 36;
	localparam int LO_BITS    = 17;

	localparam logic [GAIN_BITS-1:0] INV_GAIN = 24'd10188014;
	localparam logic [15:0]          AZ_180   = 16'd46080;
	localparam logic [16:0]          LEN_MAX  = 17'd131071;

	// port field widths
	localparam int FIELD_BITS   = 12;
	localparam int RGB_BITS     = 24;
	localparam int AZ_BITS      = 16;
	localparam int LEN_BITS     = 17;
	localparam int S_TDATA_BITS = 48;
	localparam int M_TDATA_BITS = 88;

	// box record queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// atan(2^-i) in degrees, 16 fraction bits, rounded; zero past the table
	function automatic logic [ATAN_BITS-1:0] atan_lut(input logic [4:0] idx);
		logic [ATAN_BITS-1:0] val;
		begin
			case (idx)
				5'd0:    val = 22'd2949120;
				5'd1:    val = 22'd1740967;
				5'd2:    val = 22'd919879;
				5'd3:    val = 22'd466945;
				5'd4:    val = 22'd234379;
				5'd5:    val = 22'd117304;
				5'd6:    val = 22'd58666;
				5'd7:    val = 22'd29335;
				5'd8:    val = 22'd14668;
				5'd9:    val = 22'd7334;
				5'd10:   val = 22'd3667;
				5'd11:   val = 22'd1833;
				5'd12:   val = 22'd917;
				5'd13:   val = 22'd458;
				5'd14:   val = 22'd229;
				5'd15:   val = 22'd115;
				5'd16:   val = 22'd57;
				5'd17:   val = 22'd29;
				5'd18:   val = 22'd14;
				5'd19:   val = 22'd7;
				5'd20:   val = 22'd4;
				5'd21:   val = 22'd2;
				5'd22:   val = 22'd1;
				default: val = 22'd0;
			endcase
			return val;
		end
	endfunction

endpackage

// ----- sv/pbal_queue.sv -----
// short fifo of finished box records between the pixel front and the cordic back
// depends on pbal_pkg for the queue depth
module pbal_queue
	import pbal_pkg::*;
#(
	parameter int WIDTH = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/pbal_front.sv -----
// pixel front: accepts one pixel item per cycle while the record queue is not full, and tracks the lit bounding box
// depends on pbal_pkg; hands a box record to pbal_queue on the last pixel
module pbal_front
	import pbal_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [S_TDATA_BITS-1:0]   s_tdata,
	input  logic                      s_tlast,
	output logic                      push,
	output logic [4*COORD_BITS:0]     push_data,
	input  logic                      q_full
);

	logic                  seen_q;
	logic [COORD_BITS-1:0] left_q, right_q, top_q, bottom_q;
	logic [COORD_BITS-1:0] col, row;
	logic                  lit, accept;
	logic                  seen_nx;
	logic [COORD_BITS-1:0] left_nx, right_nx, top_nx, bottom_nx;

	// unpack the item
	assign col    = COORD_BITS'(s_tdata[FIELD_BITS-1:0]);
	assign row    = COORD_BITS'(s_tdata[2*FIELD_BITS-1:FIELD_BITS]);
	assign lit    = |s_tdata[2*FIELD_BITS+RGB_BITS-1:2*FIELD_BITS];
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	// box widened by this pixel
	always_comb begin
		seen_nx   = seen_q;
		left_nx   = left_q;
		right_nx  = right_q;
		top_nx    = top_q;
		bottom_nx = bottom_q;
		if (lit) begin
			seen_nx = 1'b1;
			if (!seen_q) begin
				left_nx   = col;
				right_nx  = col;
				top_nx    = row;
				bottom_nx = row;
			end else begin
				if (col < left_q)   left_nx   = col;
				if (col > right_q)  right_nx  = col;
				if (row < top_q)    top_nx    = row;
				if (row > bottom_q) bottom_nx = row;
			end
		end
	end

	// record for the back on the last pixel
	assign push      = accept && s_tlast;
	assign push_data = {bottom_nx, top_nx, right_nx, left_nx, seen_nx};

	// box state, cleared after each image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				seen_q   <= 1'b0;
				left_q   <= '0;
				right_q  <= '0;
				top_q    <= '0;
				bottom_q <= '0;
			end else begin
				seen_q   <= seen_nx;
				left_q   <= left_nx;
				right_q  <= right_nx;
				top_q    <= top_nx;
				bottom_q <= bottom_nx;
			end
		end
	end

endmodule

// ----- sv/pbal_back.sv -----
// cordic back: turns a box record into azimuth and diagonal length
// depends on pbal_pkg; one rotation per cycle, then a two-part length multiply
module pbal_back
	import pbal_pkg::*;
#(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [4*COORD_BITS:0]   q_data,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,
	output logic                    m_tuser
);

	localparam int XW = COORD_BITS + FRAC_BITS + 3;
	localparam int UW = XW - 1;
	localparam int HW = UW - LO_BITS;
	localparam int PW = UW + GAIN_BITS;
	localparam int LW = PW - LEN_SHIFT;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int ZW = ANGLE_BITS;
	localparam int TW = ZW + 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ROT    = 5'b00010,
		ST_MUL_LO = 5'b00100,
		ST_MUL_HI = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [IW-1:0]          step_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic                   seen_q, flat_q;
	logic [COORD_BITS-1:0]  left_q, right_q, top_q, bottom_q;
	logic [AZ_BITS-1:0]     az_q;
	logic [PW-1:0]          acc_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [M_TDATA_BITS-1:0] out_data_q;

	logic [COORD_BITS-1:0]  q_left, q_right, q_top, q_bottom, ext_x, ext_y;
	logic signed [XW-1:0]   dx, dy, x_nx, y_nx;
	logic signed [ZW-1:0]   ang, z_nx;
	logic signed [TW-1:0]   z_rnd, z_shift;
	logic [AZ_BITS-1:0]     az_nx;
	logic [UW-1:0]          ux;
	logic [LO_BITS+GAIN_BITS-1:0] prod_lo;
	logic [HW+GAIN_BITS-1:0]      prod_hi;
	logic [LW-1:0]          len_raw;
	logic [LEN_BITS-1:0]    len_sat;
	logic                   out_load;

	// unpack the box record
	assign q_left   = q_data[COORD_BITS:1];
	assign q_right  = q_data[2*COORD_BITS:COORD_BITS+1];
	assign q_top    = q_data[3*COORD_BITS:2*COORD_BITS+1];
	assign q_bottom = q_data[4*COORD_BITS:3*COORD_BITS+1];
	assign ext_x    = q_right - q_left;
	assign ext_y    = q_bottom - q_top;
	assign pop      = (state_q == ST_IDLE) && !q_empty;

	// one vectoring rotation, shifts truncate toward zero
	always_comb begin
		dx  = !y_q[XW-1] ? (y_q >>> step_q) : -((-y_q) >>> step_q);
		dy  = !x_q[XW-1] ? (x_q >>> step_q) : -((-x_q) >>> step_q);
		ang = $signed({{(ZW-ATAN_BITS){1'b0}}, atan_lut(5'(step_q))});
		if (!y_q[XW-1]) begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			z_nx = z_q + ang;
		end else begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			z_nx = z_q - ang;
		end
	end

	// azimuth: round to 8 fraction bits, clamp, take from 180; zero for a flat box
	always_comb begin
		z_rnd   = TW'(z_q) + TW'(128);
		z_shift = z_rnd >>> 8;
		if (flat_q || z_rnd[TW-1]) begin
			az_nx = flat_q ? '0 : AZ_180;
		end else if (z_shift > $signed(TW'(AZ_180))) begin
			az_nx = '0;
		end else begin
			az_nx = AZ_180 - AZ_BITS'(z_shift);
		end
	end

	// length partial products on the non-negative x
	assign ux      = x_q[XW-1] ? '0 : UW'(x_q);
	assign prod_lo = (LO_BITS+GAIN_BITS)'(ux[LO_BITS-1:0]) * (LO_BITS+GAIN_BITS)'(INV_GAIN);
	assign prod_hi = (HW+GAIN_BITS)'(ux[UW-1:LO_BITS]) * (HW+GAIN_BITS)'(INV_GAIN);
	assign len_raw = acc_q[PW-1:LEN_SHIFT];
	assign len_sat = (32'(len_raw) > 32'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(len_raw);

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_ROT;
						step_q  <= '0;
					end
				end
				ST_ROT: begin
					if (step_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= ST_MUL_LO;
					end
					step_q <= step_q + 1'b1;
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				seen_q   <= q_data[0];
				left_q   <= q_left;
				right_q  <= q_right;
				top_q    <= q_top;
				bottom_q <= q_bottom;
				flat_q   <= (ext_y == '0);
				x_q      <= $signed(XW'({ext_x, {FRAC_BITS{1'b0}}}));
				y_q      <= $signed(XW'({ext_y, {FRAC_BITS{1'b0}}}));
				z_q      <= '0;
			end
			ST_ROT: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			ST_MUL_LO: begin
				az_q  <= az_nx;
				acc_q <= PW'(prod_lo) + (PW'(1) << (LEN_SHIFT - 1));
			end
			ST_MUL_HI: begin
				acc_q <= acc_q + (PW'(prod_hi) << LO_BITS);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= seen_q;
			out_data_q  <= {7'b0, len_sat, az_q,
				FIELD_BITS'(bottom_q), FIELD_BITS'(top_q),
				FIELD_BITS'(right_q), FIELD_BITS'(left_q)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

endmodule

// ----- sv/pixel_box_angle_length_core.sv -----
// Pixel bounding box with diagonal length and azimuth. Pixel items enter at
// one per cycle; the front stalls every pixel item while the record queue
// (two entries) is full. Each image's box is worked out by an iterative
// cordic in the back, which takes the record from the queue, does one
// rotation per cycle, then forms the length multiply in two parts and
// loads the output register, so images that arrive faster than the back
// finishes them back up into the front. A result waits in an output
// register; while it waits the back holds the next finished record, and the
// front keeps taking pixels until the queue fills.
module pixel_box_angle_length_core
	import pbal_pkg::*;
#(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // column[11:0], row[23:12], pixel_rgb[47:24]
	input  logic                    s_tlast,  // last_pixel
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,  // box_x_min[11:0], box_x_max[23:12],
	                                          // box_y_min[35:24], box_y_max[47:36],
	                                          // azimuth_deg[63:48], diag_length[80:64]
	output logic                    m_tuser   // any_found
);

	localparam int RW = 4 * COORD_BITS + 1;

	logic          push, q_full, pop, q_empty;
	logic [RW-1:0] push_data, pop_data;

	// pixel front
	pbal_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	// record queue
	pbal_queue #(
		.WIDTH(RW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	// cordic back
	pbal_back #(
		.COORD_BITS  (COORD_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
